@@ rtl/rvc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvc_pkg
// Shared types, opcode and field codes, and base-format encoders for the
// compressed instruction expander.
// ----------------------------------------------------------------------------
package rvc_pkg;

  typedef logic [15:0] cword_t;
  typedef logic [31:0] xword_t;
  typedef logic [6:0]  opcode_t;
  typedef logic [4:0]  reg_t;
  typedef logic [2:0]  funct3_t;
  typedef logic [6:0]  funct7_t;

  // result register contents
  typedef struct packed {
    xword_t word;
    logic   illegal;
  } result_t;

  // base opcodes
  localparam opcode_t OPC_JALR   = 7'h67;
  localparam opcode_t OPC_JAL    = 7'h6F;
  localparam opcode_t OPC_IMM    = 7'h13;
  localparam opcode_t OPC_LUI    = 7'h37;
  localparam opcode_t OPC_STORE  = 7'h23;
  localparam opcode_t OPC_LOAD   = 7'h03;
  localparam opcode_t OPC_BRANCH = 7'h63;
  localparam opcode_t OPC_OP     = 7'h33;
  localparam opcode_t OPC_OP32   = 7'h3B;
  localparam opcode_t OPC_IMM32  = 7'h1B;

  // base funct3 / funct7
  localparam funct3_t F3_ADD = 3'd0;
  localparam funct3_t F3_SLL = 3'd1;
  localparam funct3_t F3_W   = 3'd2;
  localparam funct3_t F3_D   = 3'd3;
  localparam funct3_t F3_XOR = 3'd4;
  localparam funct3_t F3_SR  = 3'd5;
  localparam funct3_t F3_OR  = 3'd6;
  localparam funct3_t F3_AND = 3'd7;
  localparam funct7_t F7_NONE = 7'h00;
  localparam funct7_t F7_SUB  = 7'h20;
  localparam logic [11:0] SRA_FLAG = 12'h400;

  // fixed registers
  localparam reg_t REG_ZERO = 5'd0;
  localparam reg_t REG_RA   = 5'd1;
  localparam reg_t REG_SP   = 5'd2;

  // compressed quadrants
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // compressed funct3, quadrant 0
  localparam funct3_t C0_ADDI4SPN = 3'd0;
  localparam funct3_t C0_LW       = 3'd2;
  localparam funct3_t C0_LD       = 3'd3;
  localparam funct3_t C0_SW       = 3'd6;
  localparam funct3_t C0_SD       = 3'd7;
  // quadrant 1
  localparam funct3_t C1_ADDI  = 3'd0;
  localparam funct3_t C1_ADDIW = 3'd1;
  localparam funct3_t C1_LI    = 3'd2;
  localparam funct3_t C1_LUI   = 3'd3;
  localparam funct3_t C1_ALU   = 3'd4;
  localparam funct3_t C1_J     = 3'd5;
  localparam funct3_t C1_BEQZ  = 3'd6;
  localparam funct3_t C1_BNEZ  = 3'd7;
  // quadrant 2
  localparam funct3_t C2_SLLI = 3'd0;
  localparam funct3_t C2_LWSP = 3'd2;
  localparam funct3_t C2_LDSP = 3'd3;
  localparam funct3_t C2_MISC = 3'd4;
  localparam funct3_t C2_SWSP = 3'd6;
  localparam funct3_t C2_SDSP = 3'd7;

  // quadrant 1 ALU sub-op, bits 11:10
  localparam logic [1:0] ALU_SRLI = 2'd0;
  localparam logic [1:0] ALU_SRAI = 2'd1;
  localparam logic [1:0] ALU_ANDI = 2'd2;
  localparam logic [1:0] ALU_REG  = 2'd3;
  // register op, bits 6:5
  localparam logic [1:0] RR_SUB = 2'd0;
  localparam logic [1:0] RR_XOR = 2'd1;
  localparam logic [1:0] RR_OR  = 2'd2;
  localparam logic [1:0] RR_AND = 2'd3;

  function automatic xword_t enc_i(opcode_t op, reg_t rd, funct3_t f3, reg_t rs1,
                                   logic [11:0] imm);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic xword_t enc_r(opcode_t op, reg_t rd, funct3_t f3, reg_t rs1,
                                   reg_t rs2, funct7_t f7);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic xword_t enc_s(opcode_t op, funct3_t f3, reg_t rs1, reg_t rs2,
                                   logic [11:0] imm);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], op};
  endfunction

  function automatic xword_t enc_b(opcode_t op, funct3_t f3, reg_t rs1,
                                   logic [12:0] imm);
    return {imm[12], imm[10:5], REG_ZERO, rs1, f3, imm[4:1], imm[11], op};
  endfunction

  function automatic xword_t enc_j(opcode_t op, reg_t rd, logic [20:0] imm);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, op};
  endfunction

endpackage

@@ rtl/rvc_instruction_expander.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvc_instruction_expander
// Two-register pipeline around the compressed instruction expander.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------
//   in      | in_valid, in_stall | compressed_word[15:0]
//   out     | out_valid,out_stall| expanded_word[31:0], illegal
//
// One transfer per cycle while out_stall is low; a result passes from the input
// register through expansion to the result register before it is valid.
// Synchronous reset clears both valid flags; payload registers are not reset.
// A stalled result holds; the input register still refills while the result
// register is empty, so in_stall rises only when both stages are full.
// ----------------------------------------------------------------------------
module rvc_instruction_expander (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  rvc_pkg::cword_t compressed_word,
  output logic            out_valid,
  input  logic            out_stall,
  output rvc_pkg::xword_t expanded_word,
  output logic            illegal
);

  logic             in_full;
  rvc_pkg::cword_t  in_word;
  rvc_pkg::result_t result;
  rvc_pkg::result_t result_next;
  logic             out_load;
  logic             in_load;

  assign out_load = !out_valid || !out_stall;
  assign in_load  = !in_full || out_load;
  assign in_stall = !in_load;

  rvc_expand u_expand (
    .c   (in_word),
    .res (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_load) begin
        in_full <= in_valid;
      end
      if (out_load) begin
        out_valid <= in_full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && in_valid) begin
      in_word <= compressed_word;
    end
    if (out_load && in_full) begin
      result <= result_next;
    end
  end

  assign expanded_word = result.word;
  assign illegal       = result.illegal;

endmodule

@@ rtl/rvc_expand.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvc_expand
// Combinational expansion of one compressed instruction into its 32-bit
// base form; unsupported encodings give zero with the illegal flag.
// ----------------------------------------------------------------------------
module rvc_expand (
  input  rvc_pkg::cword_t  c,
  output rvc_pkg::result_t res
);

  rvc_pkg::xword_t w;

  always_comb begin
    rvc_pkg::reg_t  a;
    rvc_pkg::reg_t  b;
    rvc_pkg::reg_t  a3;
    rvc_pkg::reg_t  b3;
    logic [11:0]    imm6;
    logic [11:0]    shamt;
    logic [11:0]    im_lw;
    logic [11:0]    im_ld;
    logic [20:0]    im_j;
    logic [12:0]    im_b;

    a     = c[11:7];
    b     = c[6:2];
    a3    = {2'b01, c[9:7]};
    b3    = {2'b01, c[4:2]};
    imm6  = {{6{c[12]}}, c[12], c[6:2]};
    shamt = {6'b0, c[12], c[6:2]};
    im_lw = {5'b0, c[5], c[12:10], c[6], 2'b0};
    im_ld = {4'b0, c[6:5], c[12:10], 3'b0};
    im_j  = {{10{c[12]}}, c[8], c[10:9], c[6], c[7], c[2], c[11], c[5:3], 1'b0};
    im_b  = {{5{c[12]}}, c[6:5], c[2], c[11:10], c[4:3], 1'b0};
    w     = '0;

    unique case (c[1:0])
      rvc_pkg::QUAD_0: begin
        unique case (c[15:13])
          rvc_pkg::C0_ADDI4SPN: begin
            if (c != '0) begin
              w = rvc_pkg::enc_i(rvc_pkg::OPC_IMM, b3, rvc_pkg::F3_ADD, rvc_pkg::REG_SP,
                                 {2'b0, c[10:7], c[12:11], c[5], c[6], 2'b0});
            end
          end
          rvc_pkg::C0_LW:
            w = rvc_pkg::enc_i(rvc_pkg::OPC_LOAD, b3, rvc_pkg::F3_W, a3, im_lw);
          rvc_pkg::C0_LD:
            w = rvc_pkg::enc_i(rvc_pkg::OPC_LOAD, b3, rvc_pkg::F3_D, a3, im_ld);
          rvc_pkg::C0_SW:
            w = rvc_pkg::enc_s(rvc_pkg::OPC_STORE, rvc_pkg::F3_W, a3, b3, im_lw);
          rvc_pkg::C0_SD:
            w = rvc_pkg::enc_s(rvc_pkg::OPC_STORE, rvc_pkg::F3_D, a3, b3, im_ld);
          default: w = '0;
        endcase
      end
      rvc_pkg::QUAD_1: begin
        unique case (c[15:13])
          rvc_pkg::C1_ADDI:
            w = rvc_pkg::enc_i(rvc_pkg::OPC_IMM, a, rvc_pkg::F3_ADD, a, imm6);
          rvc_pkg::C1_ADDIW:
            w = rvc_pkg::enc_i(rvc_pkg::OPC_IMM32, a, rvc_pkg::F3_ADD, a, imm6);
          rvc_pkg::C1_LI:
            w = rvc_pkg::enc_i(rvc_pkg::OPC_IMM, a, rvc_pkg::F3_ADD, rvc_pkg::REG_ZERO,
                               imm6);
          rvc_pkg::C1_LUI: begin
            if (a == rvc_pkg::REG_SP) begin
              w = rvc_pkg::enc_i(rvc_pkg::OPC_IMM, rvc_pkg::REG_SP, rvc_pkg::F3_ADD,
                                 rvc_pkg::REG_SP,
                                 {{3{c[12]}}, c[4:3], c[5], c[2], c[6], 4'b0});
            end else if (a != rvc_pkg::REG_ZERO) begin
              w = {{14{c[12]}}, c[12], c[6:2], a, rvc_pkg::OPC_LUI};
            end
          end
          rvc_pkg::C1_ALU: begin
            unique case (c[11:10])
              rvc_pkg::ALU_SRLI:
                w = rvc_pkg::enc_i(rvc_pkg::OPC_IMM, a3, rvc_pkg::F3_SR, a3, shamt);
              rvc_pkg::ALU_SRAI:
                w = rvc_pkg::enc_i(rvc_pkg::OPC_IMM, a3, rvc_pkg::F3_SR, a3,
                                   rvc_pkg::SRA_FLAG | shamt);
              rvc_pkg::ALU_ANDI:
                w = rvc_pkg::enc_i(rvc_pkg::OPC_IMM, a3, rvc_pkg::F3_AND, a3, imm6);
              rvc_pkg::ALU_REG: begin
                if (!c[12]) begin
                  unique case (c[6:5])
                    rvc_pkg::RR_SUB:
                      w = rvc_pkg::enc_r(rvc_pkg::OPC_OP, a3, rvc_pkg::F3_ADD, a3, b3,
                                         rvc_pkg::F7_SUB);
                    rvc_pkg::RR_XOR:
                      w = rvc_pkg::enc_r(rvc_pkg::OPC_OP, a3, rvc_pkg::F3_XOR, a3, b3,
                                         rvc_pkg::F7_NONE);
                    rvc_pkg::RR_OR:
                      w = rvc_pkg::enc_r(rvc_pkg::OPC_OP, a3, rvc_pkg::F3_OR, a3, b3,
                                         rvc_pkg::F7_NONE);
                    rvc_pkg::RR_AND:
                      w = rvc_pkg::enc_r(rvc_pkg::OPC_OP, a3, rvc_pkg::F3_AND, a3, b3,
                                         rvc_pkg::F7_NONE);
                    default: w = '0;
                  endcase
                end else begin
                  unique case (c[6:5])
                    rvc_pkg::RR_SUB:
                      w = rvc_pkg::enc_r(rvc_pkg::OPC_OP32, a3, rvc_pkg::F3_ADD, a3, b3,
                                         rvc_pkg::F7_SUB);
                    rvc_pkg::RR_XOR:
                      w = rvc_pkg::enc_r(rvc_pkg::OPC_OP32, a3, rvc_pkg::F3_ADD, a3, b3,
                                         rvc_pkg::F7_NONE);
                    default: w = '0;
                  endcase
                end
              end
              default: w = '0;
            endcase
          end
          rvc_pkg::C1_J:
            w = rvc_pkg::enc_j(rvc_pkg::OPC_JAL, rvc_pkg::REG_ZERO, im_j);
          rvc_pkg::C1_BEQZ, rvc_pkg::C1_BNEZ:
            w = rvc_pkg::enc_b(rvc_pkg::OPC_BRANCH, {2'b0, c[13]}, a3, im_b);
          default: w = '0;
        endcase
      end
      rvc_pkg::QUAD_2: begin
        unique case (c[15:13])
          rvc_pkg::C2_SLLI:
            w = rvc_pkg::enc_i(rvc_pkg::OPC_IMM, a, rvc_pkg::F3_SLL, a, shamt);
          rvc_pkg::C2_LWSP:
            w = rvc_pkg::enc_i(rvc_pkg::OPC_LOAD, a, rvc_pkg::F3_W, rvc_pkg::REG_SP,
                               {4'b0, c[3:2], c[12], c[6:4], 2'b0});
          rvc_pkg::C2_LDSP:
            w = rvc_pkg::enc_i(rvc_pkg::OPC_LOAD, a, rvc_pkg::F3_D, rvc_pkg::REG_SP,
                               {3'b0, c[4:2], c[12], c[6:5], 3'b0});
          rvc_pkg::C2_MISC: begin
            if (!c[12]) begin
              if (b == rvc_pkg::REG_ZERO) begin
                w = rvc_pkg::enc_i(rvc_pkg::OPC_JALR, rvc_pkg::REG_ZERO, rvc_pkg::F3_ADD,
                                   a, 12'b0);
              end else begin
                w = rvc_pkg::enc_r(rvc_pkg::OPC_OP, a, rvc_pkg::F3_ADD, rvc_pkg::REG_ZERO,
                                   b, rvc_pkg::F7_NONE);
              end
            end else if (b == rvc_pkg::REG_ZERO) begin
              // when a is zero the word stays zero and is flagged illegal
              if (a != rvc_pkg::REG_ZERO) begin
                w = rvc_pkg::enc_i(rvc_pkg::OPC_JALR, rvc_pkg::REG_RA, rvc_pkg::F3_ADD,
                                   a, 12'b0);
              end
            end else begin
              w = rvc_pkg::enc_r(rvc_pkg::OPC_OP, a, rvc_pkg::F3_ADD, a, b,
                                 rvc_pkg::F7_NONE);
            end
          end
          rvc_pkg::C2_SWSP:
            w = rvc_pkg::enc_s(rvc_pkg::OPC_STORE, rvc_pkg::F3_W, rvc_pkg::REG_SP, b,
                               {4'b0, c[8:7], c[12:9], 2'b0});
          rvc_pkg::C2_SDSP:
            w = rvc_pkg::enc_s(rvc_pkg::OPC_STORE, rvc_pkg::F3_D, rvc_pkg::REG_SP, b,
                               {3'b0, c[9:7], c[12:10], 3'b0});
          default: w = '0;
        endcase
      end
      rvc_pkg::QUAD_3: w = '0;
      default: w = '0;
    endcase
  end

  assign res.word    = w;
  assign res.illegal = (w == '0);

endmodule
